>>> rtl/core/kcl_pkg.sv
// Shared types, constants and key decoding for the keypad code lock.
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

  // Default entry capacity in symbols (top-level parameter default)
  localparam int CODE_MAX_DEFAULT = 9;

  // Master code register: nine nibbles, four-bit length
  localparam int MASTER_NIBBLES   = 9;
  localparam int MASTER_DIGITS_W  = 4 * MASTER_NIBBLES;
  localparam int MASTER_LEN_W     = 4;
  localparam logic [MASTER_DIGITS_W-1:0] MASTER_DIGITS_RST = 36'h0_0001_2345;
  localparam logic [MASTER_LEN_W-1:0]    MASTER_LEN_RST    = 4'd5;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = MASTER_DIGITS_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_DIGITS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_LENGTH = 2'd1;

  // Event byte and symbols
  localparam int EVENT_W = 8;
  localparam int SYM_W   = 4;
  localparam logic [SYM_W-1:0] SYM_STAR = 4'd10;
  localparam logic [SYM_W-1:0] SYM_HASH = 4'd11;

  // Symbols in the user code after reset: 1,2,3,4,5
  localparam int USER_RST_LEN = 5;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_LOCKED   = 2'd0,
    MODE_UNLOCKED = 2'd1,
    MODE_MASTER   = 2'd2,
    MODE_NEWCODE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OUT_TAKEN   = 3'd0,
    OUT_PASS    = 3'd1,
    OUT_FAIL    = 3'd2,
    OUT_CHANGED = 3'd3,
    OUT_CANCEL  = 3'd4,
    OUT_LEFT    = 3'd5
  } outcome_t;

  // Decoded key
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } key_dec_t;

  // Front to queue
  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] sym;
  } push_t;

  // Queue head towards the back
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } q_head_t;

  // One result item
  typedef struct packed {
    logic [SYM_W-1:0] key_symbol;
    mode_t            mode_after;
    outcome_t         outcome;
    logic             door_unlocked;
  } result_t;

  // Key number (from one) to symbol on the 4x3 matrix; rows are ten apart
  function automatic key_dec_t decode_key(input logic [EVENT_W-2:0] n);
    key_dec_t d;
    d.hit = 1'b1;
    d.sym = '0;
    case (n)
      7'd1:    d.sym = 4'd1;
      7'd2:    d.sym = 4'd2;
      7'd3:    d.sym = 4'd3;
      7'd11:   d.sym = 4'd4;
      7'd12:   d.sym = 4'd5;
      7'd13:   d.sym = 4'd6;
      7'd21:   d.sym = 4'd7;
      7'd22:   d.sym = 4'd8;
      7'd23:   d.sym = 4'd9;
      7'd31:   d.sym = SYM_STAR;
      7'd32:   d.sym = 4'd0;
      7'd33:   d.sym = SYM_HASH;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kcl_front.sv
// Front end: takes event items, drops releases and off-matrix keys, queues symbols.
`timescale 1ns / 1ps
`default_nettype none

module kcl_front
  import kcl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [EVENT_W-1:0] in_key_event,
  input  wire logic               q_full,
  output push_t                   q_push
);

  key_dec_t dec;

  // Room in the queue is all that holds an item back
  assign in_ready = !q_full;

  // Press bit and matrix decode
  always_comb begin
    dec         = decode_key(in_key_event[EVENT_W-2:0]);
    q_push.sym  = dec.sym;
    q_push.push = in_valid && in_ready && in_key_event[EVENT_W-1] && dec.hit;
  end

`ifndef SYNTH
  // Nothing is queued while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.push)
    else $error("push while queue full");

  // A release never reaches the queue
  a_release_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    !in_key_event[EVENT_W-1] |-> !q_push.push)
    else $error("release event queued");

  // Only a completed handshake pushes
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> (in_valid && in_ready))
    else $error("push without accepted item");
`endif

endmodule

`default_nettype wire

>>> rtl/core/kcl_queue.sv
// Short symbol queue between the front end and the lock engine.
`timescale 1ns / 1ps
`default_nettype none

module kcl_queue
  import kcl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t q_push,
  input  wire logic  q_pop,
  output logic       q_full,
  output q_head_t    q_head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [SYM_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign q_full       = (count_r == CNT_FULL);
  assign q_head.valid = (count_r != '0);
  assign q_head.sym   = slot_r[rd_ptr_r];
  assign do_pop       = q_pop && q_head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_push.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slot_r[wr_ptr_r] <= q_push.sym;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kcl_back.sv
// Lock engine: mode machine, entry buffer, code compares and result register.
`timescale 1ns / 1ps
`default_nettype none

module kcl_back
  import kcl_pkg::*;
#(
  parameter int CODE_MAX_SYMBOLS = CODE_MAX_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire q_head_t                q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output result_t                     out_res
);

  localparam int CNT_W = $clog2(CODE_MAX_SYMBOLS + 1);
  localparam int CMP_W = (CNT_W > MASTER_LEN_W) ? CNT_W : MASTER_LEN_W;
  localparam int PAD_W = (CODE_MAX_SYMBOLS > MASTER_NIBBLES) ?
                         SYM_W * CODE_MAX_SYMBOLS : MASTER_DIGITS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CODE_MAX_SYMBOLS);

  // Configuration registers
  logic [MASTER_DIGITS_W-1:0] master_digits_r;
  logic [MASTER_LEN_W-1:0]    master_len_r;

  // Lock state
  mode_t            mode_r, mode_nxt;
  logic [SYM_W-1:0] entry_r [CODE_MAX_SYMBOLS];
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [SYM_W-1:0] user_r [CODE_MAX_SYMBOLS];
  logic [CNT_W-1:0] user_count_r;

  // Result register
  logic    out_valid_r;
  result_t out_res_r;

  logic             is_star, is_hash;
  logic             match_user, match_master;
  logic             do_append, do_clear, do_copy;
  outcome_t         outcome;
  logic [PAD_W-1:0] master_pad;

  assign q_pop     = q_head.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign is_star   = (q_head.sym == SYM_STAR);
  assign is_hash   = (q_head.sym == SYM_HASH);
  assign master_pad = PAD_W'(master_digits_r);

  // Parallel code compares, one lane per buffer position
  always_comb begin
    match_user   = (entry_count_r == user_count_r);
    match_master = (CMP_W'(entry_count_r) == CMP_W'(master_len_r));
    for (int i = 0; i < CODE_MAX_SYMBOLS; i++) begin
      if (CNT_W'(i) < entry_count_r) begin
        if (entry_r[i] != user_r[i]) begin
          match_user = 1'b0;
        end
        if (entry_r[i] != master_pad[SYM_W*i +: SYM_W]) begin
          match_master = 1'b0;
        end
      end
    end
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    if (q_pop) begin
      case (mode_r)
        MODE_LOCKED: begin
          if (is_star && match_user) mode_nxt = MODE_UNLOCKED;
        end
        MODE_UNLOCKED: begin
          if (is_hash)      mode_nxt = MODE_LOCKED;
          else if (is_star) mode_nxt = MODE_MASTER;
        end
        MODE_MASTER: begin
          if (is_hash)                        mode_nxt = MODE_UNLOCKED;
          else if (is_star && match_master)   mode_nxt = MODE_NEWCODE;
        end
        MODE_NEWCODE: begin
          if (is_hash || is_star) mode_nxt = MODE_UNLOCKED;
        end
        default: mode_nxt = MODE_LOCKED;
      endcase
    end
  end

  // Per-mode actions and outcome
  always_comb begin
    outcome   = OUT_TAKEN;
    do_append = 1'b0;
    do_clear  = 1'b0;
    do_copy   = 1'b0;
    case (mode_r)
      MODE_LOCKED: begin
        if (is_star) begin
          outcome  = match_user ? OUT_PASS : OUT_FAIL;
          do_clear = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      MODE_UNLOCKED: begin
        if (is_hash || is_star) begin
          outcome  = OUT_LEFT;
          do_clear = 1'b1;
        end
      end
      MODE_MASTER: begin
        if (is_hash) begin
          outcome  = OUT_CANCEL;
          do_clear = 1'b1;
        end else if (is_star) begin
          outcome  = match_master ? OUT_PASS : OUT_FAIL;
          do_clear = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      MODE_NEWCODE: begin
        if (is_hash) begin
          outcome  = OUT_CANCEL;
          do_clear = 1'b1;
        end else if (is_star) begin
          outcome  = OUT_CHANGED;
          do_copy  = 1'b1;
          do_clear = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
      default: begin
        outcome = OUT_TAKEN;
      end
    endcase
  end

  // Entry count: full buffer drops further keys
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (q_pop) begin
      if (do_clear) begin
        entry_count_nxt = '0;
      end else if (do_append && (entry_count_r < CNT_MAX)) begin
        entry_count_nxt = entry_count_r + 1'b1;
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LOCKED;
      entry_count_r   <= '0;
      user_count_r    <= CNT_W'(USER_RST_LEN);
      out_valid_r     <= 1'b0;
      master_digits_r <= MASTER_DIGITS_RST;
      master_len_r    <= MASTER_LEN_RST;
      for (int i = 0; i < CODE_MAX_SYMBOLS; i++) begin
        user_r[i] <= (i < USER_RST_LEN) ? SYM_W'(i + 1) : '0;
      end
    end else begin
      mode_r        <= mode_nxt;
      entry_count_r <= entry_count_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && do_copy) begin
        user_count_r <= entry_count_r;
        for (int i = 0; i < CODE_MAX_SYMBOLS; i++) begin
          user_r[i] <= entry_r[i];
        end
      end
      if (cfg_we && (cfg_index == CFG_MASTER_DIGITS)) begin
        master_digits_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == CFG_MASTER_LENGTH)) begin
        master_len_r <= cfg_wdata[MASTER_LEN_W-1:0];
      end
    end
  end

  // Entry buffer and result payload
  always_ff @(posedge clk) begin
    if (q_pop && do_append) begin
      for (int i = 0; i < CODE_MAX_SYMBOLS; i++) begin
        if (entry_count_r == CNT_W'(i)) begin
          entry_r[i] <= q_head.sym;
        end
      end
    end
    if (q_pop) begin
      out_res_r.key_symbol    <= q_head.sym;
      out_res_r.mode_after    <= mode_nxt;
      out_res_r.outcome       <= outcome;
      out_res_r.door_unlocked <= (mode_nxt != MODE_LOCKED);
    end
  end

`ifndef SYNTH
  // Entry count never exceeds the buffer
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_MAX)
    else $error("entry count beyond capacity");

  // Any mode change leaves an empty entry buffer
  a_clear_on_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (mode_nxt != mode_r)) |=> (entry_count_r == '0))
    else $error("entry not cleared on mode change");

  // A failed compare keeps the mode and clears the entry
  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (outcome == OUT_FAIL)) |=>
      ((mode_r == $past(mode_r)) && (entry_count_r == '0)))
    else $error("failed compare changed mode or kept entry");

  // Reported mode matches the live mode once a result is loaded
  a_result_mode: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && (out_res_r.mode_after == mode_r)))
    else $error("result mode differs from lock mode");
`endif

endmodule

`default_nettype wire

>>> rtl/core/keypad_code_lock_fsm_top.sv
// Top level of the keypad code lock: front end, symbol queue and lock engine.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_key_event[7:0]
//  out_     output     out_valid/out_ready  key_symbol, mode_after, outcome, door_unlocked
//  cfg_     input      cfg_we (no wait)     cfg_index[1:0], cfg_wdata[35:0]
//
// One item per cycle sustained while out_ready stays high. An accepted key press is
// written first into the two-entry symbol queue, then into the result register, which
// raises out_valid. Releases and off-matrix keys are taken in the same cycle and give
// no result. Synchronous active-low reset: locked, empty entry, user code 1,2,3,4,5,
// master code keyed as 5,4,3,2,1 (register value 0x12345); no clearing pass. A stalled
// output fills the queue, then drops in_ready.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_fsm_top
  import kcl_pkg::*;
#(
  parameter int CODE_MAX_SYMBOLS = CODE_MAX_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [EVENT_W-1:0]     in_key_event,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SYM_W-1:0]            out_key_symbol,
  output logic [1:0]                  out_mode_after,
  output logic [2:0]                  out_outcome,
  output logic                        out_door_unlocked,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  push_t   q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;
  result_t res;

  kcl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_event (in_key_event),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  kcl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  kcl_back #(
    .CODE_MAX_SYMBOLS (CODE_MAX_SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Result fields onto their ports
  assign out_key_symbol    = res.key_symbol;
  assign out_mode_after    = res.mode_after;
  assign out_outcome       = res.outcome;
  assign out_door_unlocked = res.door_unlocked;

endmodule

`default_nettype wire
